/* design/omni_wheel_velocity_to_pwm_defines.svh */
// Assertion macros for the omni wheel velocity to PWM block.
// Used by the checker module only; expects clk and rst_n in scope.
`ifndef OMNI_WHEEL_VELOCITY_TO_PWM_DEFINES_SVH
`define OMNI_WHEEL_VELOCITY_TO_PWM_DEFINES_SVH

// Checked on every clock edge outside reset.
`define OWVP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define OWVP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/owvp_pkg.sv */
// Shared types and constants for the omni wheel velocity to PWM block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package owvp_pkg;

  localparam int PWM_BITS_DEF = 12;
  localparam int NST          = 8;   // pipeline depth from input to output register

  // Configuration register indexes.
  localparam logic [2:0] REG_SINE     = 3'd0;
  localparam logic [2:0] REG_COSINE   = 3'd1;
  localparam logic [2:0] REG_INV_RAD  = 3'd2;
  localparam logic [2:0] REG_BODY     = 3'd3;
  localparam logic [2:0] REG_DEADBAND = 3'd4;
  localparam logic [2:0] REG_GAIN     = 3'd5;
  localparam logic [2:0] REG_OFFSET   = 3'd6;

  // Mixing coefficients in Q0.16.
  localparam logic signed [16:0] MIX_TWO_THIRDS  = 17'sd43691;
  localparam logic signed [16:0] MIX_ONE_THIRD   = 17'sd21845;
  localparam logic signed [16:0] MIX_ROOT3_THIRD = 17'sd37837;

  localparam int AB_W  = 33;  // rotated translation, Q26
  localparam int MIX_W = 50;  // mixed wheel sum, Q42
  localparam int T_W   = 24;  // mixed sum after the floor shift by 26

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] spin_rate;
  } in_item_t;

  typedef struct packed {
    logic [11:0] pwm_one;
    logic [11:0] pwm_two;
    logic [11:0] pwm_three;
    logic        dir_one;
    logic        dir_two;
    logic        dir_three;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] heading_sine;
    logic signed [15:0] heading_cosine;
    logic [15:0]        inv_wheel_radius;
    logic [15:0]        body_to_wheel;
    logic [15:0]        speed_deadband;
    logic [15:0]        pwm_gain;
    logic [15:0]        pwm_offset;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    heading_sine:     16'sd2,
    heading_cosine:   -16'sd16384,
    inv_wheel_radius: 16'd4876,
    body_to_wheel:    16'd11796,
    speed_deadband:   16'd57,
    pwm_gain:         16'd5941,
    pwm_offset:       16'd9272
  };

  // Load enables of the pipeline stages, one per register stage.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
    logic s7;
    logic s8;
  } pipe_en_t;

endpackage

/* design/omni_wheel_velocity_to_pwm.sv */
// Top level of the omni wheel velocity to PWM block: configuration registers,
// stage valid bits and stall control. Depends on owvp_pkg, owvp_rotate,
// owvp_mix and owvp_drive.
//
//   port group  direction  handshake             payload
//   in_         request    in_valid / in_stall    in_data   (in_item_t)
//   out_        result     out_valid / out_stall  out_data  (out_item_t)
//   cfg_        write      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A request passes from the edge that accepts it into the output register by way
// of eight register stages: products, rotation, mixing products, mixing
// sums, radius product, magnitude, gain product and PWM. One request enters per
// cycle while results are taken. A stalled result holds and the stages behind it
// fill their empty slots, so the input stalls only once every stage is full.
// Reset clears the valid bits and loads the configuration defaults.
`timescale 1ns / 1ps

module omni_wheel_velocity_to_pwm
  import owvp_pkg::*;
#(
  parameter int PWM_BITS = PWM_BITS_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_regs_t cfg_r, cfg_nxt;
  logic [NST:1] vld_r, vld_nxt;
  logic [NST:1] ld;
  pipe_en_t     en;

  logic signed [AB_W-1:0] a_w, b_w;
  logic signed [32:0]     spin_w;
  logic signed [T_W-1:0]  t1_w, t2_w, t3_w;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SINE:     cfg_nxt.heading_sine     = $signed(cfg_data);
        REG_COSINE:   cfg_nxt.heading_cosine   = $signed(cfg_data);
        REG_INV_RAD:  cfg_nxt.inv_wheel_radius = cfg_data;
        REG_BODY:     cfg_nxt.body_to_wheel    = cfg_data;
        REG_DEADBAND: cfg_nxt.speed_deadband   = cfg_data;
        REG_GAIN:     cfg_nxt.pwm_gain         = cfg_data;
        REG_OFFSET:   cfg_nxt.pwm_offset       = cfg_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    ld[NST] = !vld_r[NST] || !out_stall;
    for (int k = NST - 1; k >= 1; k--) begin
      ld[k] = !vld_r[k] || ld[k+1];
    end
    vld_nxt[1] = ld[1] ? in_valid : vld_r[1];
    for (int k = 2; k <= NST; k++) begin
      vld_nxt[k] = ld[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  assign en = '{s1: ld[1], s2: ld[2], s3: ld[3], s4: ld[4],
                s5: ld[5], s6: ld[6], s7: ld[7], s8: ld[8]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
      vld_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !ld[1];
  assign out_valid = vld_r[NST];

  owvp_rotate u_rotate (
    .clk      (clk),
    .en       (en),
    .item     (in_data),
    .cfg      (cfg_r),
    .a_out    (a_w),
    .b_out    (b_w),
    .spin_out (spin_w)
  );

  owvp_mix u_mix (
    .clk     (clk),
    .en      (en),
    .a_in    (a_w),
    .b_in    (b_w),
    .spin_in (spin_w),
    .t_one   (t1_w),
    .t_two   (t2_w),
    .t_three (t3_w)
  );

  owvp_drive #(.PWM_BITS(PWM_BITS)) u_drive_one (
    .clk  (clk),
    .en   (en),
    .t_in (t1_w),
    .cfg  (cfg_r),
    .pwm  (out_data.pwm_one),
    .dir  (out_data.dir_one)
  );

  owvp_drive #(.PWM_BITS(PWM_BITS)) u_drive_two (
    .clk  (clk),
    .en   (en),
    .t_in (t2_w),
    .cfg  (cfg_r),
    .pwm  (out_data.pwm_two),
    .dir  (out_data.dir_two)
  );

  owvp_drive #(.PWM_BITS(PWM_BITS)) u_drive_three (
    .clk  (clk),
    .en   (en),
    .t_in (t3_w),
    .cfg  (cfg_r),
    .pwm  (out_data.pwm_three),
    .dir  (out_data.dir_three)
  );

endmodule

/* design/owvp_rotate.sv */
// Stages one and two: heading rotation of the translation and the spin product.
// Depends on owvp_pkg.
`timescale 1ns / 1ps

module owvp_rotate
  import owvp_pkg::*;
(
  input  logic                   clk,
  input  pipe_en_t               en,
  input  in_item_t               item,
  input  cfg_regs_t              cfg,
  output logic signed [AB_W-1:0] a_out,
  output logic signed [AB_W-1:0] b_out,
  output logic signed [32:0]     spin_out
);

  logic signed [31:0] xs_r, yc_r, ys_r, xc_r;
  logic signed [31:0] xs_nxt, yc_nxt, ys_nxt, xc_nxt;
  logic signed [32:0] wh_r, wh_nxt;
  logic signed [AB_W-1:0] a_r, b_r, a_nxt, b_nxt;
  logic signed [32:0] spin_r;

  assign xs_nxt = item.vel_x * cfg.heading_sine;
  assign yc_nxt = item.vel_y * cfg.heading_cosine;
  assign ys_nxt = item.vel_y * cfg.heading_sine;
  assign xc_nxt = item.vel_x * cfg.heading_cosine;
  assign wh_nxt = item.spin_rate * $signed({1'b0, cfg.body_to_wheel});

  assign a_nxt = {xs_r[31], xs_r} - {yc_r[31], yc_r};
  assign b_nxt = {ys_r[31], ys_r} + {xc_r[31], xc_r};

  always_ff @(posedge clk) begin
    if (en.s1) begin
      xs_r <= xs_nxt;
      yc_r <= yc_nxt;
      ys_r <= ys_nxt;
      xc_r <= xc_nxt;
      wh_r <= wh_nxt;
    end
    if (en.s2) begin
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      spin_r <= wh_r;
    end
  end

  assign a_out    = a_r;
  assign b_out    = b_r;
  assign spin_out = spin_r;

endmodule

/* design/owvp_mix.sv */
// Stages three and four: three-wheel mixing and the reduction to Q16.
// Depends on owvp_pkg.
`timescale 1ns / 1ps

module owvp_mix
  import owvp_pkg::*;
(
  input  logic                   clk,
  input  pipe_en_t               en,
  input  logic signed [AB_W-1:0] a_in,
  input  logic signed [AB_W-1:0] b_in,
  input  logic signed [32:0]     spin_in,
  output logic signed [T_W-1:0]  t_one,
  output logic signed [T_W-1:0]  t_two,
  output logic signed [T_W-1:0]  t_three
);

  logic signed [MIX_W-1:0] ka2_r, ka1_r, kb_r;
  logic signed [MIX_W-1:0] ka2_nxt, ka1_nxt, kb_nxt;
  logic signed [32:0]      spin_r;
  logic signed [MIX_W-1:0] spin_q42;
  logic signed [MIX_W-1:0] m1, m2, m3;
  logic signed [T_W-1:0]   t1_r, t2_r, t3_r;

  assign ka2_nxt = MIX_W'(a_in) * MIX_W'(MIX_TWO_THIRDS);
  assign ka1_nxt = MIX_W'(a_in) * MIX_W'(MIX_ONE_THIRD);
  assign kb_nxt  = MIX_W'(b_in) * MIX_W'(MIX_ROOT3_THIRD);

  // The spin term is brought to Q42 by a left shift of 14.
  assign spin_q42 = {{(MIX_W - 47){spin_r[32]}}, spin_r, 14'b0};

  assign m1 = ka2_r + spin_q42;
  assign m2 = kb_r - ka1_r + spin_q42;
  assign m3 = spin_q42 - ka1_r - kb_r;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      ka2_r  <= ka2_nxt;
      ka1_r  <= ka1_nxt;
      kb_r   <= kb_nxt;
      spin_r <= spin_in;
    end
    if (en.s4) begin
      // Dropping the low 26 bits of a two's complement value is a floor shift.
      t1_r <= m1[MIX_W-1:26];
      t2_r <= m2[MIX_W-1:26];
      t3_r <= m3[MIX_W-1:26];
    end
  end

  assign t_one   = t1_r;
  assign t_two   = t2_r;
  assign t_three = t3_r;

endmodule

/* design/owvp_drive.sv */
// Stages five to eight for one wheel: radius scaling, direction, deadband and PWM.
// Depends on owvp_pkg.
`timescale 1ns / 1ps

module owvp_drive
  import owvp_pkg::*;
#(
  parameter int PWM_BITS = PWM_BITS_DEF
)
(
  input  logic                  clk,
  input  pipe_en_t              en,
  input  logic signed [T_W-1:0] t_in,
  input  cfg_regs_t             cfg,
  output logic [11:0]           pwm,
  output logic                  dir
);

  localparam int PROD_W = T_W + 17;
  localparam int W_W    = PROD_W - 8;
  localparam int GP_W   = W_W + 16;
  localparam int SUM_W  = GP_W + 1;
  localparam int P_W    = SUM_W - 24;
  localparam logic [P_W-1:0] PMAX = (P_W'(1) << PWM_BITS) - P_W'(1);

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [W_W-1:0]    w;
  logic [W_W-1:0]           mag_r, mag_nxt;
  logic                     dir6_r, dir7_r, dir8_r;
  logic [GP_W-1:0]          gp_r, gp_nxt;
  logic                     zero_r, zero_nxt;
  logic [SUM_W-1:0]         sum;
  logic [P_W-1:0]           p, p_sat;
  logic [11:0]              pwm_r, pwm_nxt;

  assign prod_nxt = PROD_W'(t_in) * PROD_W'($signed({1'b0, cfg.inv_wheel_radius}));

  // Floor shift by 8 of the scaled speed.
  assign w       = prod_r[PROD_W-1:8];
  assign mag_nxt = w[W_W-1] ? (W_W'(0) - W_W'(w)) : W_W'(w);

  assign gp_nxt   = GP_W'(cfg.pwm_gain) * GP_W'(mag_r);
  assign zero_nxt = mag_r <= W_W'({cfg.speed_deadband, 8'b0});

  assign sum   = SUM_W'(gp_r) + SUM_W'({cfg.pwm_offset, 16'b0});
  assign p     = sum[SUM_W-1:24];
  assign p_sat = (p > PMAX) ? PMAX : p;

  always_comb begin
    pwm_nxt = 12'(p_sat);
    if (zero_r) begin
      pwm_nxt = 12'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      prod_r <= prod_nxt;
    end
    if (en.s6) begin
      mag_r  <= mag_nxt;
      dir6_r <= ~w[W_W-1];
    end
    if (en.s7) begin
      gp_r   <= gp_nxt;
      zero_r <= zero_nxt;
      dir7_r <= dir6_r;
    end
    if (en.s8) begin
      pwm_r  <= pwm_nxt;
      dir8_r <= dir7_r;
    end
  end

  assign pwm = pwm_r;
  assign dir = dir8_r;

endmodule

/* design/owvp_checker.sv */
// Port-level checker for omni_wheel_velocity_to_pwm, bound to the top level.
// Depends on owvp_pkg and omni_wheel_velocity_to_pwm_defines.svh.
`timescale 1ns / 1ps
`include "omni_wheel_velocity_to_pwm_defines.svh"

module owvp_checker
  import owvp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled result stays offered and unchanged.
  `OWVP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `OWVP_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_data), "stalled result changed")

  // Requests are refused only when the pipeline is full behind a stalled result.
  `OWVP_ASSERT(a_in_stall_cause, in_stall |-> out_valid && out_stall, "input stalled with room left")

  `OWVP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result offered after reset")

endmodule

bind omni_wheel_velocity_to_pwm owvp_checker u_owvp_checker (.*);

/* tb/omni_wheel_velocity_to_pwm_tb.sv */
// Self-checking testbench for the omni wheel velocity to PWM block.
// Depends on owvp_pkg and omni_wheel_velocity_to_pwm; predicts every wheel
// result in a scoreboard class and drives the ports from plain tasks.
`timescale 1ns / 1ps

module omni_wheel_velocity_to_pwm_tb
  import owvp_pkg::*;
();

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam longint PWM_MAX = (64'sd1 <<< PWM_BITS_DEF) - 1;

  class pwm_checker;
    cfg_regs_t regs;
    out_item_t awaited_pwm[$];
    int errors;

    function new();
      regs = CFG_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] value);
      case (idx)
        REG_SINE:     regs.heading_sine = value;
        REG_COSINE:   regs.heading_cosine = value;
        REG_INV_RAD:  regs.inv_wheel_radius = value;
        REG_BODY:     regs.body_to_wheel = value;
        REG_DEADBAND: regs.speed_deadband = value;
        REG_GAIN:     regs.pwm_gain = value;
        REG_OFFSET:   regs.pwm_offset = value;
        default: ;
      endcase
    endfunction

    // Turns one mixed sum at Q42 into the PWM magnitude and direction bit.
    function void drive_wheel(longint mix, output logic [11:0] pwm, output logic dir);
      longint t16, w, mag, p;
      t16 = mix >>> 26;
      w = (t16 * longint'(regs.inv_wheel_radius)) >>> 8;
      mag = (w < 0) ? -w : w;
      dir = (w >= 0);
      if (mag <= (longint'(regs.speed_deadband) <<< 8)) begin
        p = 0;
      end else begin
        p = (longint'(regs.pwm_gain) * mag + (longint'(regs.pwm_offset) <<< 16)) >>> 24;
        if (p > PWM_MAX) p = PWM_MAX;
      end
      pwm = p[11:0];
    endfunction

    function out_item_t wheel_pwm_for(in_item_t cmd);
      longint x, y, z, s, c, a, b, spin;
      out_item_t r;
      x = longint'(cmd.vel_x);
      y = longint'(cmd.vel_y);
      z = longint'(cmd.spin_rate);
      s = longint'(regs.heading_sine);
      c = longint'(regs.heading_cosine);
      a = x * s - y * c;
      b = y * s + x * c;
      spin = z * longint'(regs.body_to_wheel) * 16384;
      drive_wheel(longint'(MIX_TWO_THIRDS) * a + spin, r.pwm_one, r.dir_one);
      drive_wheel(-longint'(MIX_ONE_THIRD) * a + longint'(MIX_ROOT3_THIRD) * b + spin,
                  r.pwm_two, r.dir_two);
      drive_wheel(-longint'(MIX_ONE_THIRD) * a - longint'(MIX_ROOT3_THIRD) * b + spin,
                  r.pwm_three, r.dir_three);
      return r;
    endfunction

    function void note_request(in_item_t cmd);
      awaited_pwm.push_back(wheel_pwm_for(cmd));
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited_pwm.size() == 0) begin
        $display("%0t: result with no request outstanding, got %p", $time, got);
        errors++;
        return;
      end
      want = awaited_pwm.pop_front();
      compare("pwm_one", 16'(want.pwm_one), 16'(got.pwm_one));
      compare("pwm_two", 16'(want.pwm_two), 16'(got.pwm_two));
      compare("pwm_three", 16'(want.pwm_three), 16'(got.pwm_three));
      compare("dir_one", 16'(want.dir_one), 16'(got.dir_one));
      compare("dir_two", 16'(want.dir_two), 16'(got.dir_two));
      compare("dir_three", 16'(want.dir_three), 16'(got.dir_three));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  pwm_checker book = new();
  bit idle_on = 1'b1;
  int hold_cycles = 0;

  always #2 clk = ~clk;

  omni_wheel_velocity_to_pwm dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) book.check_result(out_data);
  end

  // Output back-pressure: a long hold when asked for, otherwise short random bursts while idle_on is set.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("omni_wheel_velocity_to_pwm_tb: errors");
    $finish;
  end

  function automatic logic signed [15:0] pick_speed();
    int k;
    k = $urandom_range(0, 13);
    case ($urandom_range(0, 5))
      0, 1: return 16'($urandom);
      2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      3, 4: return 16'($signed($urandom_range(0, 2 ** (k + 1))) - 2 ** k);
      default: return 16'($urandom_range(0, 2)) - 16'sd1;
    endcase
  endfunction

  // Leaves cfg_valid high so that back-to-back writes never lower and raise it in one step.
  task automatic cfg_write(logic [2:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    book.set_reg(idx, value);
  endtask

  task automatic send_request(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
    in_item_t cmd;
    cmd.vel_x = x;
    cmd.vel_y = y;
    cmd.spin_rate = z;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (in_stall);
    book.note_request(cmd);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (book.awaited_pwm.size() != 0);
  endtask

  task automatic load_setting(int p);
    cfg_regs_t s;
    s = {$urandom, $urandom, $urandom, 16'($urandom)};
    case (p)
      1: s = '{16'sh8000, 16'sh7FFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF};
      2: s = '{16'sd16384, 16'sd0, 16'd4876, 16'd11796, 16'd57, 16'd5941, 16'd9272};
      3: s = '0;
      4: begin
        s.heading_sine = -16'sd16384;
        s.heading_cosine = 16'sd16384;
        s.speed_deadband = 16'hFFFF;
        s.pwm_offset = '0;
      end
      5: begin
        s.heading_sine = 16'($signed($urandom_range(0, 32768)) - 16384);
        s.heading_cosine = 16'($signed($urandom_range(0, 32768)) - 16384);
        s.speed_deadband = 16'($urandom_range(0, 255));
      end
      7: s = '{16'sh7FFF, 16'sh8000, 16'd256, 16'd0, 16'd0, 16'd256, 16'd0};
      default: ;
    endcase
    cfg_write(REG_SINE, s.heading_sine);
    cfg_write(REG_COSINE, s.heading_cosine);
    cfg_write(REG_INV_RAD, s.inv_wheel_radius);
    cfg_write(REG_BODY, s.body_to_wheel);
    cfg_write(REG_DEADBAND, s.speed_deadband);
    cfg_write(REG_GAIN, s.pwm_gain);
    cfg_write(REG_OFFSET, s.pwm_offset);
    cfg_write(REG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic stream_random(int n, int hold_at, int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_cycles = 80;
      if (i == pause_at) begin
        in_valid <= 1'b0;
        wait_drained();
      end
      send_request(pick_speed(), pick_speed(), pick_speed());
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // A write beyond the last register must leave the defaults untouched.
    cfg_write(REG_UNUSED, 16'hFFFF);
    cfg_valid <= 1'b0;

    send_request(16'sd0, 16'sd0, 16'sd0);
    send_request(16'sh7FFF, 16'sd0, 16'sd0);
    send_request(16'sh8000, 16'sd0, 16'sd0);
    send_request(16'sd0, 16'sh7FFF, 16'sd0);
    send_request(16'sd0, 16'sh8000, 16'sd0);
    send_request(16'sd0, 16'sd0, 16'sh7FFF);
    send_request(16'sd0, 16'sd0, 16'sh8000);
    send_request(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_request(16'sh8000, 16'sh8000, 16'sh8000);
    send_request(16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_request(16'sh8000, 16'sh7FFF, 16'sh8000);
    // Tiny speeds either side of zero; the floor shifts round their small products down.
    send_request(16'sd1, 16'sd0, 16'sd0);
    send_request(-16'sd1, 16'sd0, 16'sd0);
    send_request(16'sd0, 16'sd1, 16'sd0);
    send_request(16'sd0, -16'sd1, 16'sd0);
    send_request(16'sd0, 16'sd0, 16'sd1);
    send_request(16'sd0, 16'sd0, -16'sd1);
    send_request(-16'sd1, -16'sd1, -16'sd1);
    send_request(16'sd4096, 16'sd0, 16'sd0);
    send_request(16'sd0, 16'sd4096, 16'sd0);
    send_request(16'sd0, 16'sd0, 16'sd4096);
    send_request(16'sh5555, 16'shAAAA, 16'sh5555);
    in_valid <= 1'b0;

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      load_setting(p);
      idle_on = (p == 7) ? 1'b0 : ($urandom_range(0, 3) != 0);
      stream_random(154, (p == 2) ? 40 : -1, (p == 4) ? 70 : -1);
    end

    wait_drained();
    repeat (NST + 4) @(posedge clk);
    if (book.errors == 0 && book.awaited_pwm.size() == 0) begin
      $display("omni_wheel_velocity_to_pwm_tb: clean");
    end else begin
      $display("omni_wheel_velocity_to_pwm_tb: errors");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/owvp_pkg.sv
design/owvp_rotate.sv
design/owvp_mix.sv
design/owvp_drive.sv
design/omni_wheel_velocity_to_pwm.sv
design/owvp_checker.sv
tb/omni_wheel_velocity_to_pwm_tb.sv
